### src/lsbe_pkg.sv
// ----------------------------------------------------------------------------
// lsbe_pkg: shared constants and types for the LED strip bit encoder
// Holds default sizes, register codes, reset values and the bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsbe_pkg;

  // default sizes handed to the top level
  localparam int LED_COUNT_DEF   = 16;
  localparam int RESET_SLOTS_DEF = 50;

  // bits per LED, green-red-blue, eight bits each
  localparam int LED_BITS = 24;
  localparam int CHAN_W   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BRIGHT_W   = 6;
  localparam int CODE_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE    = 2'd3;

  // register reset values
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX     = 6'd45;
  localparam logic [CODE_W-1:0]   ONE_CODE_RST   = 16'd60;
  localparam logic [CODE_W-1:0]   ZERO_CODE_RST  = 16'd30;

  // divide by 45 as multiply by reciprocal and shift; exact for products
  // up to 255 * 45
  localparam int SCALE_DEN   = 45;
  localparam int SCALE_SHIFT = 19;
  localparam int PROD_W      = CHAN_W + BRIGHT_W;
  localparam logic [PROD_W-1:0] SCALE_RECIP =
    PROD_W'(((1 << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN);

  // controller to datapath commands
  typedef struct packed {
    logic wr;          // store the input colour
    logic start_led;   // read colour at pointer, advance pointer
    logic start_tail;  // rewind pointer, clear slot counter
    logic mul1;        // channel times brightness
    logic mul2;        // divide by 45
    logic emit_bit;    // load one bit code into the output register
    logic emit_tail;   // load one zero tail code into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ptr_end;     // every LED sent
    logic out_free;    // output register can take a code this cycle
    logic bit_last;    // counter on the final bit of an LED
    logic tail_last;   // counter on the final tail slot
  } sts_t;

endpackage

### src/lsbe_ctrl.sv
// ----------------------------------------------------------------------------
// lsbe_ctrl: sequencing state machine
// Accepts one item at a time, steps the datapath through read, scale and
// emission of bit codes or the reset tail.
// ----------------------------------------------------------------------------
module lsbe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_stall,
  input  lsbe_pkg::sts_t  sts,
  output lsbe_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_SEND = 5'b01000,
    ST_TAIL = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_op) begin
            cmd.wr = 1'b1;
          end else if (sts.ptr_end) begin
            cmd.start_tail = 1'b1;
            state_nxt      = ST_TAIL;
          end else begin
            cmd.start_led = 1'b1;
            state_nxt     = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        cmd.emit_bit = sts.out_free;
        if (sts.out_free && sts.bit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TAIL: begin
        cmd.emit_tail = sts.out_free;
        if (sts.out_free && sts.tail_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/lsbe_dpath.sv
// ----------------------------------------------------------------------------
// lsbe_dpath: colour store, brightness scaling and code output register
// Holds the configuration registers, the per-LED colour memory with its
// valid bits, the send pointer, the scaler and the bit shifter.
// ----------------------------------------------------------------------------
module lsbe_dpath #(
  parameter int LED_COUNT   = lsbe_pkg::LED_COUNT_DEF,
  parameter int RESET_SLOTS = lsbe_pkg::RESET_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [7:0]                        in_led_index,
  input  logic [lsbe_pkg::CHAN_W-1:0]       in_red,
  input  logic [lsbe_pkg::CHAN_W-1:0]       in_green,
  input  logic [lsbe_pkg::CHAN_W-1:0]       in_blue,
  input  logic                              cfg_wr_en,
  input  logic [lsbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsbe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  lsbe_pkg::cmd_t                    cmd,
  output lsbe_pkg::sts_t                    sts,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [lsbe_pkg::CODE_W-1:0]       out_duty_code,
  output logic                              out_last_of_run,
  output logic                              out_frame_end
);

  localparam int IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int PTR_W  = $clog2(LED_COUNT + 1);
  localparam int CNT_MAX = (RESET_SLOTS > lsbe_pkg::LED_BITS) ? RESET_SLOTS
                                                             : lsbe_pkg::LED_BITS;
  localparam int CNT_W  = $clog2(CNT_MAX);
  localparam int BITS   = lsbe_pkg::LED_BITS;
  localparam int CW     = lsbe_pkg::CHAN_W;
  localparam int PW     = lsbe_pkg::PROD_W;
  localparam int SH     = lsbe_pkg::SCALE_SHIFT;

  // configuration registers
  logic [lsbe_pkg::BRIGHT_W-1:0] bright_r;
  logic                          bright_en_r;
  logic [lsbe_pkg::CODE_W-1:0]   one_code_r;
  logic [lsbe_pkg::CODE_W-1:0]   zero_code_r;
  logic [lsbe_pkg::BRIGHT_W-1:0] bright_wr;

  // colour store
  logic [BITS-1:0]      mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld_r;
  logic [BITS-1:0]      rd_data_r;
  logic                 rd_vld_r;
  logic                 wr_hit;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_idx;

  // pointer, counter, scaler, shifter
  logic [PTR_W-1:0]          ptr_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [BITS-1:0]           raw;
  logic [BITS-1:0]           raw_r;
  logic [2:0][PW-1:0]        prod_nxt;
  logic [2:0][PW-1:0]        prod_r;
  logic [2:0][2*PW-1:0]      quot_full;
  logic [BITS-1:0]           scaled;
  logic [BITS-1:0]           word_r;

  // output register
  logic                        out_valid_r;
  logic [lsbe_pkg::CODE_W-1:0] code_r;
  logic                        last_r;
  logic                        tail_r;

  // clamp brightness writes to the scale denominator
  assign bright_wr = (cfg_wdata[lsbe_pkg::BRIGHT_W-1:0] > lsbe_pkg::BRIGHT_MAX)
                     ? lsbe_pkg::BRIGHT_MAX : cfg_wdata[lsbe_pkg::BRIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= lsbe_pkg::BRIGHT_MAX;
      bright_en_r <= 1'b1;
      one_code_r  <= lsbe_pkg::ONE_CODE_RST;
      zero_code_r <= lsbe_pkg::ZERO_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lsbe_pkg::CFG_BRIGHTNESS: bright_r    <= bright_wr;
        lsbe_pkg::CFG_BRIGHT_EN:  bright_en_r <= cfg_wdata[0];
        lsbe_pkg::CFG_ONE_CODE:   one_code_r  <= cfg_wdata;
        lsbe_pkg::CFG_ZERO_CODE:  zero_code_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // drop writes beyond the strip
  assign wr_hit = cmd.wr && (in_led_index < 8'(LED_COUNT));
  assign wr_idx = in_led_index[IDX_W-1:0];
  assign rd_idx = ptr_r[IDX_W-1:0];

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_idx] <= {in_green, in_red, in_blue};
    end
    if (cmd.start_led) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // entry valid bits: an unwritten entry reads as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (cmd.start_led) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  // advance or rewind the send pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.start_tail) begin
      ptr_r <= '0;
    end else if (cmd.start_led) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // slot counter: cleared at the start of each send step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start_led || cmd.start_tail) begin
      cnt_r <= '0;
    end else if (cmd.emit_bit || cmd.emit_tail) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // scale each channel: multiply by brightness, then by reciprocal of 45
  assign raw = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i]  = PW'(raw[i*CW +: CW]) * PW'(bright_r);
      quot_full[i] = (2*PW)'(prod_r[i]) * (2*PW)'(lsbe_pkg::SCALE_RECIP);
      scaled[i*CW +: CW] = quot_full[i][SH +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_r <= prod_nxt;
      raw_r  <= raw;
    end
    if (cmd.mul2) begin
      word_r <= bright_en_r ? scaled : raw_r;
    end else if (cmd.emit_bit) begin
      word_r <= {word_r[BITS-2:0], 1'b0};
    end
  end

  // output register: load a code when free, drop valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_bit || cmd.emit_tail) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bit) begin
      code_r <= word_r[BITS-1] ? one_code_r : zero_code_r;
      last_r <= sts.bit_last;
      tail_r <= 1'b0;
    end else if (cmd.emit_tail) begin
      code_r <= '0;
      last_r <= sts.tail_last;
      tail_r <= 1'b1;
    end
  end

  // status to the controller
  assign sts.ptr_end   = (ptr_r == PTR_W'(LED_COUNT));
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.bit_last  = (cnt_r == CNT_W'(BITS - 1));
  assign sts.tail_last = (cnt_r == CNT_W'(RESET_SLOTS - 1));

  assign out_valid       = out_valid_r;
  assign out_duty_code   = code_r;
  assign out_last_of_run = last_r;
  assign out_frame_end   = tail_r;

endmodule

### src/led_strip_bit_encoder.sv
// ----------------------------------------------------------------------------
// led_strip_bit_encoder: colour store to pulse code stream for an LED strip
// Stores one colour per LED and emits per-bit pulse compare codes.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall): op 0 writes red, green and blue at
//  led_index (ignored beyond the strip) and sends no item out.
//  Op 1 is a send step: it emits the 24 codes of the LED at the send pointer,
//  green-red-blue, MSB first, or, once every LED has gone, a tail of
//  RESET_SLOTS zero codes with frame_end set, which rewinds the pointer.
//  Output channel (out_valid / out_stall): one code per item, last_of_run
//  marks the final code of a send step.
//  The first LED code passes through the colour memory read, the brightness
//  multiply and the divide by 45 before the output register; a tail code
//  goes straight to the output register, the single register that every code
//  passes through. Codes then leave one per cycle while the output does not
//  stall. One item is worked on at a time; the next is taken once the final
//  code sits in the output register.
//  A stall on the output holds the current code and pauses the sequence.
//  Reset clears the colour store to black, the pointer to the first LED and
//  the registers to brightness 45, scaling on, codes 60 and 30.
// ----------------------------------------------------------------------------
module led_strip_bit_encoder #(
  parameter int LED_COUNT   = lsbe_pkg::LED_COUNT_DEF,
  parameter int RESET_SLOTS = lsbe_pkg::RESET_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [7:0]                        in_led_index,
  input  logic [lsbe_pkg::CHAN_W-1:0]       in_red,
  input  logic [lsbe_pkg::CHAN_W-1:0]       in_green,
  input  logic [lsbe_pkg::CHAN_W-1:0]       in_blue,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lsbe_pkg::CODE_W-1:0]       out_duty_code,
  output logic                              out_last_of_run,
  output logic                              out_frame_end,
  input  logic                              cfg_wr_en,
  input  logic [lsbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsbe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  lsbe_pkg::cmd_t cmd;
  lsbe_pkg::sts_t sts;

  // sequencing
  lsbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, scaling and output
  lsbe_dpath #(
    .LED_COUNT   (LED_COUNT),
    .RESET_SLOTS (RESET_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_led_index    (in_led_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_duty_code   (out_duty_code),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule

### src/lsbe_chk.sv
// ----------------------------------------------------------------------------
// lsbe_chk: port-level checks for the LED strip bit encoder
// Watches the top level's ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module lsbe_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [lsbe_pkg::CODE_W-1:0]     out_duty_code,
  input logic                            out_last_of_run,
  input logic                            out_frame_end
);

  // tail codes are always zero
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_duty_code == '0)
    else $error("tail code not zero");

  // no new item taken while a run is still being emitted
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("input taken mid run");

  // a taken non-final code is followed straight away by the next one
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a run");

  // a stalled code holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_code)
      && $stable(out_last_of_run) && $stable(out_frame_end))
    else $error("stalled code changed");

endmodule

bind led_strip_bit_encoder lsbe_chk u_lsbe_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_duty_code   (out_duty_code),
  .out_last_of_run (out_last_of_run),
  .out_frame_end   (out_frame_end)
);
